>>> rtl/tkh_pkg.sv
// Shared types and constants of the top-K min-heap keeper.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package tkh_pkg;

  localparam int TKH_DEPTH = 1024;
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 20;
  localparam int CNT_W     = 11;
  localparam int STATUS_W  = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1000;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_EVICTED   = 3'd1,
    ST_BELOW     = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_EXTRACTED = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DN_RD,
    S_DN_CMP,
    S_UP_INIT,
    S_UP_RD,
    S_UP_CMP,
    S_DONE
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;     // latch item, read root and last entry
    logic    set_status;
    status_t code;
    logic    pop_init;   // take root out, last entry becomes moving entry
    logic    dn_read;    // read both children of parent
    logic    dn_step;    // move chosen child up one level
    logic    dn_final;   // place moving entry at parent
    logic    up_init;    // open a slot at the end
    logic    up_read;    // read parent of slot
    logic    up_step;    // move parent down into slot
    logic    up_final;   // place new entry at slot
    logic    emit;       // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic win;
    logic empty;
    logic full;
    logic below;
    logic dn_more;
    logic dn_stop;
    logic up_root;
    logic up_stop;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/tkh_if.sv
// Valid/ready channel interfaces for items in and results out.
// Depends on tkh_pkg for field widths.
`default_nettype none

interface tkh_in_if import tkh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] new_key;
  logic [TAG_W-1:0] new_tag;
  logic             in_window;

  modport source (output valid, operation, new_key, new_tag, in_window, input ready);
  modport sink   (input valid, operation, new_key, new_tag, in_window, output ready);
endinterface

interface tkh_out_if import tkh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [TAG_W-1:0]    out_tag;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, status, out_key, out_tag, entry_count, input ready);
  modport sink   (input valid, status, out_key, out_tag, entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/tkh_ctrl.sv
// Sequencing state machine of the top-K heap: pop, sift down, sift up, emit.
// Depends on tkh_pkg for the state, command and status types.
`default_nettype none

module tkh_ctrl import tkh_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        push_pending, push_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      push_pending <= 1'b0;
    end else begin
      state        <= state_next;
      push_pending <= push_pending_next;
    end
  end

  always_comb begin
    state_next        = state;
    push_pending_next = push_pending;
    cmd               = '0;
    cmd.code          = ST_INSERTED;
    in_ready          = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.set_status = 1'b1;
        if (stat.op == OP_EXTRACT) begin
          if (stat.empty) begin
            cmd.code   = ST_EMPTY;
            state_next = S_DONE;
          end else begin
            cmd.code          = ST_EXTRACTED;
            cmd.pop_init      = 1'b1;
            push_pending_next = 1'b0;
            state_next        = S_DN_RD;
          end
        end else if (!stat.win) begin
          cmd.code   = ST_OUTSIDE;
          state_next = S_DONE;
        end else if (stat.full) begin
          if (stat.below) begin
            cmd.code   = ST_BELOW;
            state_next = S_DONE;
          end else begin
            cmd.code          = ST_EVICTED;
            cmd.pop_init      = 1'b1;
            push_pending_next = 1'b1;
            state_next        = S_DN_RD;
          end
        end else begin
          cmd.code   = ST_INSERTED;
          state_next = S_UP_INIT;
        end
      end
      S_DN_RD: begin
        if (stat.dn_more) begin
          cmd.dn_read = 1'b1;
          state_next  = S_DN_CMP;
        end else begin
          cmd.dn_final = 1'b1;
          state_next   = push_pending ? S_UP_INIT : S_DONE;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_stop) begin
          cmd.dn_final = 1'b1;
          state_next   = push_pending ? S_UP_INIT : S_DONE;
        end else begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_RD;
        end
      end
      S_UP_INIT: begin
        cmd.up_init = 1'b1;
        state_next  = S_UP_RD;
      end
      S_UP_RD: begin
        if (stat.up_root) begin
          cmd.up_final = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.up_read = 1'b1;
          state_next  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_stop) begin
          cmd.up_final = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.up_step = 1'b1;
          state_next  = S_UP_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tkh_dp.sv
// Datapath of the top-K heap: heap memory, index registers, compares, output register.
// Depends on tkh_pkg; driven by tkh_ctrl commands.
`default_nettype none

module tkh_dp import tkh_pkg::*; #(
  parameter int DEPTH = TKH_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_wr_en,
  input  wire [CNT_W-1:0]     cfg_wr_data,
  input  wire                 operation,
  input  wire [KEY_W-1:0]     new_key,
  input  wire [TAG_W-1:0]     new_tag,
  input  wire                 in_window,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    out_key,
  output logic [TAG_W-1:0]    out_tag,
  output logic [CNT_W-1:0]    entry_count,
  input  cmd_t                cmd,
  output stat_t               stat
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam int EW = KEY_W + TAG_W;

  // heap memory, one write and two registered reads per cycle
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd0, rd1;
  logic [IW-1:0] ra0, ra1, wa;
  logic [EW-1:0] wd;
  logic          we;

  logic [CNT_W-1:0] cap;
  logic [CW-1:0]    cnt;
  logic             op, win;
  logic [KEY_W-1:0] key, lk;
  logic [TAG_W-1:0] tag, lt;
  logic [IW-1:0]    parent;
  logic [CW-1:0]    child;
  logic [CW-1:0]    up_i;
  status_t          res_status;
  logic [KEY_W-1:0] res_key;
  logic [TAG_W-1:0] res_tag;

  logic [KEY_W-1:0] k0, k1, kc;
  logic [CW-1:0]    child_r;
  logic             sel_right;
  logic [IW-1:0]    chosen;
  logic [EW-1:0]    chosen_ent;
  logic [CW-1:0]    up_p;
  logic [31:0]      cap_eff;
  logic [CW+CNT_W-1:0] cnt_ext;

  assign k0         = rd0[EW-1:TAG_W];
  assign k1         = rd1[EW-1:TAG_W];
  assign child_r    = child + CW'(1);
  assign sel_right  = (child_r < cnt) && (k0 > k1);
  assign kc         = sel_right ? k1 : k0;
  assign chosen     = sel_right ? child_r[IW-1:0] : child[IW-1:0];
  assign chosen_ent = sel_right ? rd1 : rd0;
  assign up_p       = (up_i - CW'(1)) >> 1;

  // capacity clamped to 1..DEPTH
  always_comb begin
    cap_eff = 32'(cap);
    if (cap_eff == 32'd0) cap_eff = 32'd1;
    if (cap_eff > 32'(DEPTH)) cap_eff = 32'(DEPTH);
  end

  always_comb begin
    ra0 = '0;
    ra1 = '0;
    if (cmd.accept) begin
      ra1 = IW'(cnt - CW'(1));
    end else if (cmd.dn_read) begin
      ra0 = child[IW-1:0];
      ra1 = child_r[IW-1:0];
    end else if (cmd.up_read) begin
      ra0 = up_p[IW-1:0];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = parent;
    wd = {lk, lt};
    if (cmd.dn_step) begin
      we = 1'b1;
      wd = chosen_ent;
    end else if (cmd.dn_final) begin
      we = 1'b1;
    end else if (cmd.up_step) begin
      we = 1'b1;
      wa = up_i[IW-1:0];
      wd = rd0;
    end else if (cmd.up_final) begin
      we = 1'b1;
      wa = up_i[IW-1:0];
      wd = {key, tag};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) cap <= cfg_wr_data;
      if (cmd.pop_init)     cnt <= cnt - CW'(1);
      else if (cmd.up_init) cnt <= cnt + CW'(1);
      if (cmd.emit)         out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  assign cnt_ext = {{CNT_W{1'b0}}, cnt};

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= operation;
      win     <= in_window;
      key     <= new_key;
      tag     <= new_tag;
      res_key <= '0;
      res_tag <= '0;
    end
    if (cmd.set_status) res_status <= cmd.code;
    if (cmd.pop_init) begin
      res_key <= k0;
      res_tag <= rd0[TAG_W-1:0];
      lk      <= k1;
      lt      <= rd1[TAG_W-1:0];
      parent  <= '0;
      child   <= CW'(1);
    end
    if (cmd.dn_step) begin
      parent <= chosen;
      child  <= {chosen, 1'b1};
    end
    if (cmd.up_init) up_i <= cnt;
    if (cmd.up_step) up_i <= up_p;
    if (cmd.emit) begin
      status      <= res_status;
      out_key     <= res_key;
      out_tag     <= res_tag;
      entry_count <= cnt_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    stat.op       = op;
    stat.win      = win;
    stat.empty    = (cnt == '0);
    stat.full     = (32'(cnt) >= cap_eff);
    stat.below    = (key < k0);
    stat.dn_more  = (child < cnt);
    stat.dn_stop  = (lk < kc);
    stat.up_root  = (up_i == '0);
    stat.up_stop  = !(key < k0);
    stat.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> rtl/top_k_min_heap.sv
// Top-K keeper: a bounded binary min-heap of (key, tag) pairs held in on-chip memory.
// Instantiates tkh_ctrl and tkh_dp; uses tkh_pkg and the channel interfaces in tkh_if.
//
// The block keeps the largest keys seen, up to the capacity register (clamped to
// 1..DEPTH, reset 1000), with the smallest kept key at the root. Each transaction
// on in_ch is an insert or an extract and yields exactly one result transaction on
// out_ch. An insert outside the window is rejected; when full, a key below the root
// is rejected, otherwise the root is evicted and reported. One item is worked on at
// a time. An item that leaves the heap alone (outside window, below root, extract on
// empty) goes through accept, decide and emit. A sift-down runs a read and a compare
// state per level the moving entry drops (both children are read together from the
// dual-read heap memory, compared in the next state), then places it at a leaf or
// where a compare stops it. A sift-up opens the slot at the end, runs a read and a
// compare state per level the new entry climbs, then places it at the root or where
// a compare stops it. A finished result sits in the output register, so the next
// transaction is taken while it waits. Capacity must be written by the user only
// while the block is idle; the block does not enforce this. The heap memory needs no
// clearing after reset: only entries below the held count ever reach a result.
`default_nettype none

module top_k_min_heap import tkh_pkg::*; #(
  parameter int DEPTH = TKH_DEPTH
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             cfg_wr_en,
  input  wire [CNT_W-1:0] cfg_wr_data,
  tkh_in_if.sink          in_ch,
  tkh_out_if.source       out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  tkh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap storage and compares
  tkh_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .operation   (in_ch.operation),
    .new_key     (in_ch.new_key),
    .new_tag     (in_ch.new_tag),
    .in_window   (in_ch.in_window),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .status      (out_ch.status),
    .out_key     (out_ch.out_key),
    .out_tag     (out_ch.out_tag),
    .entry_count (out_ch.entry_count),
    .cmd         (cmd),
    .stat        (stat)
  );

  // one item in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction accepted while busy");

  // result codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.status <= ST_EMPTY))
    else $error("undefined result status");

  // rejected or empty results carry no entry
  a_no_entry: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == ST_BELOW || out_ch.status == ST_OUTSIDE ||
                      out_ch.status == ST_EMPTY))
      |-> (out_ch.out_key == '0 && out_ch.out_tag == '0))
    else $error("rejected result carries key or tag");

  // after an insert the heap is never empty
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == ST_INSERTED || out_ch.status == ST_EVICTED))
      |-> (out_ch.entry_count != '0))
    else $error("insert left heap empty");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the top-K min-heap keeper (top_k_min_heap).
// Needs tkh_pkg and the tkh_in_if / tkh_out_if channel interfaces from the RTL.

// Tracks the heap alongside the block and checks results in order.
class topk_tracker;
  typedef struct {
    tkh_pkg::status_t             status;
    logic [tkh_pkg::KEY_W-1:0]    key;
    logic [tkh_pkg::TAG_W-1:0]    tag;
    logic [tkh_pkg::CNT_W-1:0]    count;
  } heap_result_t;

  logic [tkh_pkg::KEY_W-1:0] keys [tkh_pkg::TKH_DEPTH];
  logic [tkh_pkg::TAG_W-1:0] tags [tkh_pkg::TKH_DEPTH];
  int unsigned               held;
  logic [tkh_pkg::CNT_W-1:0] cap_reg;
  heap_result_t              expected_q[$];
  int unsigned               errors;
  int unsigned               checked;
  int unsigned               status_seen [6];

  function new();
    held    = 0;
    cap_reg = tkh_pkg::CAP_RESET;
  endfunction

  function void set_capacity(logic [tkh_pkg::CNT_W-1:0] value);
    cap_reg = value;
  endfunction

  // capacity register clamped to 1..DEPTH
  function int unsigned full_at();
    if (cap_reg == 0) return 1;
    if (cap_reg > tkh_pkg::TKH_DEPTH) return tkh_pkg::TKH_DEPTH;
    return cap_reg;
  endfunction

  function logic [tkh_pkg::KEY_W-1:0] root_key();
    return (held != 0) ? keys[0] : '0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // pop the root, last entry sifts down; right child only when left is strictly larger
  function void take_root(output logic [tkh_pkg::KEY_W-1:0] k,
                          output logic [tkh_pkg::TAG_W-1:0] t);
    int unsigned last;
    int unsigned parent;
    int unsigned child;
    logic [tkh_pkg::KEY_W-1:0] mk;
    logic [tkh_pkg::TAG_W-1:0] mt;
    k      = keys[0];
    t      = tags[0];
    last   = held - 1;
    mk     = keys[last];
    mt     = tags[last];
    held   = last;
    parent = 0;
    child  = 1;
    while (child < last) begin
      if (child + 1 < last && keys[child] > keys[child + 1]) child++;
      if (mk < keys[child]) break;
      keys[parent] = keys[child];
      tags[parent] = tags[child];
      parent       = child;
      child        = 2 * child + 1;
    end
    keys[parent] = mk;
    tags[parent] = mt;
  endfunction

  // append at the end and sift up with strict less-than
  function void add_entry(logic [tkh_pkg::KEY_W-1:0] k, logic [tkh_pkg::TAG_W-1:0] t);
    int unsigned slot;
    int unsigned parent;
    slot = held;
    held = held + 1;
    while (slot != 0) begin
      parent = (slot - 1) / 2;
      if (!(k < keys[parent])) break;
      keys[slot] = keys[parent];
      tags[slot] = tags[parent];
      slot       = parent;
    end
    keys[slot] = k;
    tags[slot] = t;
  endfunction

  function void note_item(logic op, logic [tkh_pkg::KEY_W-1:0] key,
                          logic [tkh_pkg::TAG_W-1:0] tag, logic win);
    heap_result_t r;
    r.key = '0;
    r.tag = '0;
    if (op == tkh_pkg::OP_EXTRACT) begin
      if (held == 0) begin
        r.status = tkh_pkg::ST_EMPTY;
      end else begin
        take_root(r.key, r.tag);
        r.status = tkh_pkg::ST_EXTRACTED;
      end
    end else if (!win) begin
      r.status = tkh_pkg::ST_OUTSIDE;
    end else if (held >= full_at()) begin
      if (key < keys[0]) begin
        r.status = tkh_pkg::ST_BELOW;
      end else begin
        take_root(r.key, r.tag);
        add_entry(key, tag);
        r.status = tkh_pkg::ST_EVICTED;
      end
    end else begin
      add_entry(key, tag);
      r.status = tkh_pkg::ST_INSERTED;
    end
    r.count = held[tkh_pkg::CNT_W-1:0];
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("ERROR: %s", msg);
  endtask

  task check_result(logic [tkh_pkg::STATUS_W-1:0] status, logic [tkh_pkg::KEY_W-1:0] key,
                    logic [tkh_pkg::TAG_W-1:0] tag, logic [tkh_pkg::CNT_W-1:0] count);
    heap_result_t r;
    if (expected_q.size() == 0) begin
      report($sformatf("result with nothing outstanding: status %0d key %0h", status, key));
    end else begin
      r = expected_q.pop_front();
      checked++;
      status_seen[r.status]++;
      if (status !== r.status)
        report($sformatf("result %0d status %0d, want %s", checked, status, r.status.name()));
      if (key !== r.key)
        report($sformatf("result %0d out_key %0h, want %0h", checked, key, r.key));
      if (tag !== r.tag)
        report($sformatf("result %0d out_tag %0h, want %0h", checked, tag, r.tag));
      if (count !== r.count)
        report($sformatf("result %0d entry_count %0d, want %0d", checked, count, r.count));
    end
  endtask
endclass

module tb import tkh_pkg::*; ();

  // Max cycles with no transaction on either channel; the limit covers the longest
  // eviction on a full 1024-entry heap plus sender gaps and sink stalls.
  localparam int STALL_LIMIT = 4000;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  tkh_in_if  in_ch ();
  tkh_out_if out_ch ();

  top_k_min_heap u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  topk_tracker tracker = new();

  int unsigned tx_idle_pct;    // chance per cycle that the sender holds off
  int unsigned rx_idle_pct;    // chance per cycle that the sink drops ready
  int unsigned items_sent;
  int unsigned cap_writes;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result sink: random backpressure; every accepted transaction is checked.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
          tracker.check_result(out_ch.status, out_ch.out_key, out_ch.out_tag,
                               out_ch.entry_count);
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either side resets the stall counter.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                 (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, tracker.pending());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item, with random hold-off first; returns at the accepting edge.
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag, input logic win);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.new_key   <= key;
    in_ch.new_tag   <= tag;
    in_ch.in_window <= win;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_item(op, key, tag, win);
    items_sent++;
  endtask

  // Sender goes quiet until every outstanding result has been taken.
  // Always waits for a clock edge so valid never sees two updates in a step.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Capacity changes only while the block is idle.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_capacity(value);
    cap_writes++;
  endtask

  // Mostly in-window inserts so the heap fills and evicts; keys are biased
  // toward the current root, toward ties and toward the field extremes.
  task automatic send_random();
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    tag = TAG_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: key = $urandom;
      4, 5:       key = $urandom_range(15);
      6:          key = tracker.root_key();
      7: begin
        if ($urandom_range(1)) key = tracker.root_key() + 1;
        else key = tracker.root_key() - 1;
      end
      8:          key = $urandom_range(1) ? '1 : '0;
      default:    key = 32'hFFFF_FFF0 | $urandom_range(15);
    endcase
    pick = $urandom_range(99);
    if (pick < 70)      send_item(OP_INSERT, key, tag, 1'b1);
    else if (pick < 90) send_item(OP_EXTRACT, key, tag, 1'($urandom_range(1)));
    else                send_item(OP_INSERT, key, tag, 1'b0);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] cap, input int unsigned n);
    write_capacity(cap);
    repeat (n) send_random();
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_INSERT;
    in_ch.new_key   <= '0;
    in_ch.new_tag   <= '0;
    in_ch.in_window <= 1'b0;
    items_sent  = 0;
    cap_writes  = 0;
    tx_idle_pct = 23;
    rx_idle_pct = 53;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at the reset capacity: empty heap, window, extremes, ties.
    send_item(OP_EXTRACT, '1, '1, 1'b1);               // extract on empty
    send_item(OP_EXTRACT, '0, '0, 1'b0);               // empty, window bit ignored
    send_item(OP_INSERT, '1, '1, 1'b0);                // outside window
    send_item(OP_INSERT, '0, '0, 1'b1);
    send_item(OP_INSERT, '1, '1, 1'b1);
    send_item(OP_INSERT, 32'h8000_0000, 20'h8_0000, 1'b1);
    send_item(OP_INSERT, '0, 20'h1_2345, 1'b1);        // tie with the root
    send_item(OP_EXTRACT, 32'h5A5A_5A5A, 20'hA_5A5A, 1'b0);
    send_item(OP_EXTRACT, '0, '0, 1'b1);

    // Capacity 3: fill, then below root, equal to root, above root.
    write_capacity(11'd3);
    send_item(OP_INSERT, 32'd500, 20'd1, 1'b1);
    send_item(OP_INSERT, 32'd499, 20'd2, 1'b1);        // strictly below: rejected
    send_item(OP_INSERT, 32'd500, 20'd3, 1'b1);        // equal to root: evicts it
    send_item(OP_INSERT, '1, 20'd4, 1'b1);
    send_item(OP_INSERT, '0, 20'd5, 1'b0);             // outside window while full
    repeat (4) send_item(OP_EXTRACT, '0, '0, 1'b1);    // drain past empty

    // Capacity zero behaves as one.
    write_capacity(11'd0);
    send_item(OP_INSERT, 32'd7, 20'd6, 1'b1);
    send_item(OP_INSERT, 32'd6, 20'd7, 1'b1);
    send_item(OP_INSERT, 32'd7, 20'd8, 1'b1);
    send_item(OP_EXTRACT, '0, '0, 1'b1);

    // Random: heap contents carry across phases, so a smaller capacity often
    // lands below the current count and the heap is already over-full.
    run_phase(11'd1000, 80);
    run_phase(11'd16, 60);
    run_phase(11'd2, 60);

    tx_idle_pct = 53;
    rx_idle_pct = 23;
    run_phase(11'd2047, 80);                           // clamps to DEPTH
    run_phase(11'd5, 60);
    run_phase(11'd1, 60);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(11'd1024, 80);
    run_phase(11'd64, 60);
    run_phase(11'd9, 60);

    wait_for_results();
    repeat (60) @(posedge clk);                        // catch stray results
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));

    $display("%0d items, %0d capacity writes, %0d results checked, %0d mismatches",
             items_sent, cap_writes, tracker.checked, tracker.errors);
    $display("inserted %0d, evicted %0d, below root %0d, outside %0d, extracted %0d, empty %0d",
             tracker.status_seen[ST_INSERTED], tracker.status_seen[ST_EVICTED],
             tracker.status_seen[ST_BELOW], tracker.status_seen[ST_OUTSIDE],
             tracker.status_seen[ST_EXTRACTED], tracker.status_seen[ST_EMPTY]);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
